// ----- rtl/core/trs_pkg.sv -----
// Shared constants, types and elaboration-time functions of the term relevance scorer.
`timescale 1ns / 1ps

package trs_pkg;

   localparam int FRAC_BITS = 16;          // fraction bits of log, exp and score
   localparam int DIV_W     = 49;          // dividend and quotient width of the divider
   localparam int DEN_W     = 32;          // divisor width of the divider
   localparam int LOG_W     = 49;          // operand width of the log unit
   localparam int MSB_W     = 6;

   localparam logic [31:0] LN2_Q32   = 32'hB172_17F7;
   localparam logic [39:0] SCORE_MAX = '1;
   localparam logic [16:0] ONE_Q16   = 17'h1_0000;

   typedef enum logic [2:0] {
      CSR_SLOPE  = 3'd0,
      CSR_MU     = 3'd1,
      CSR_ALPHA  = 3'd2,
      CSR_LAMBDA = 3'd3,
      CSR_AVG    = 3'd4,
      CSR_DOCS   = 3'd5,
      CSR_TOKENS = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [MSB_W-1:0]     msb;
      logic [FRAC_BITS-1:0] frac;
   } log_type;

   // Integer square root, bit by bit.
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b != '0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // 2^(2^-k) in Q1.30: k-fold square root of two.
   function automatic logic [30:0] exp2_root(input int k);
      logic [63:0] c;
      c = 64'd2 << 30;
      for (int j = 1; j <= FRAC_BITS; j++) begin
         if (j <= k) begin
            c = isqrt64(c << 30);
         end
      end
      return c[30:0];
   endfunction

endpackage

// ----- rtl/core/term_relevance_scorer.sv -----
// Top level of the term relevance scorer: config registers and the scoring pipeline.
`timescale 1ns / 1ps
//
// Scores one matched query term against one document per transfer.
// req channel: one transfer carries term_in_doc, doc_length, docs_with_term,
//   term_in_corpus and term_in_query packed in req_tdata.
// rsp channel: one transfer per request, in order; rsp_tdata is the score in
//   unsigned Q24.16, rsp_tuser is set when the score saturated at all ones.
// csr port: write csr_wdata to register csr_addr whenever csr_wen is high;
//   write only while no request is in flight.
// Longest path: length normalization, with a 49-stage divider for the pivot,
//   a 22-stage log2, a multiply, a 16-stage exp2, a multiply and a shift.
// Throughput: one transfer per cycle, sustained, while rsp_tready stays high.
// Stall: the whole pipeline advances on one enable; while the output holds an
//   untaken result, req_tready drops, every stage holds, nothing is lost.
// Reset: clears the valid pipeline and loads the register defaults; the block
//   is ready as soon as reset is low.
//
module term_relevance_scorer import trs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // term_in_doc[15:0], doc_length[39:16], docs_with_term[63:40],
   // term_in_corpus[95:64], term_in_query[103:96]
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // score[39:0]
   output logic [39:0]  rsp_tdata,
   // clipped[0]
   output logic         rsp_tuser,
   input  logic         csr_wen,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int DEPTH = 92;

   // ---------------- configuration registers ----------------
   logic [16:0] slope_ff;
   logic [15:0] mu_ff;
   logic [16:0] alpha_ff;
   logic [16:0] lambda_ff;
   logic [31:0] avg_ff;
   logic [23:0] docs_ff;
   logic [31:0] tokens_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff  <= 17'd13107;
         mu_ff     <= 16'd2000;
         alpha_ff  <= 17'd19661;
         lambda_ff <= 17'd45875;
         avg_ff    <= 32'd256;
         docs_ff   <= 24'd1;
         tokens_ff <= 32'd1;
      end else if (csr_wen) begin
         case (csr_idx_type'(csr_addr))
            CSR_SLOPE:  slope_ff  <= csr_wdata[16:0];
            CSR_MU:     mu_ff     <= csr_wdata[15:0];
            CSR_ALPHA:  alpha_ff  <= csr_wdata[16:0];
            CSR_LAMBDA: lambda_ff <= csr_wdata[16:0];
            CSR_AVG:    avg_ff    <= csr_wdata;
            CSR_DOCS:   docs_ff   <= csr_wdata[23:0];
            CSR_TOKENS: tokens_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // clamp weights to one, replace zero divisors by one
   logic [16:0] s_eff;
   logic [16:0] alpha_eff;
   logic [16:0] lambda_eff;
   logic [15:0] mu_eff;
   logic [31:0] avg_eff;
   logic [31:0] tok_eff;

   assign s_eff      = (slope_ff  > ONE_Q16) ? ONE_Q16 : slope_ff;
   assign alpha_eff  = (alpha_ff  > ONE_Q16) ? ONE_Q16 : alpha_ff;
   assign lambda_eff = (lambda_ff > ONE_Q16) ? ONE_Q16 : lambda_ff;
   assign mu_eff     = (mu_ff == '0) ? 16'd1 : mu_ff;
   assign avg_eff    = (avg_ff == '0) ? 32'd1 : avg_ff;
   assign tok_eff    = (tokens_ff == '0) ? 32'd1 : tokens_ff;

   // ---------------- pipeline control ----------------
   logic             en;
   logic [DEPTH-1:0] vld_ff;

   // advance everything together unless a finished result waits
   assign en         = !rsp_tvalid || rsp_tready;
   // take no transfer while reset is held
   assign req_tready = en && !reset;
   assign rsp_tvalid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // ---------------- stage T0: capture the request ----------------
   logic [15:0] tf_ff;
   logic [23:0] dl_ff;
   logic [23:0] df_ff;
   logic [31:0] ctf_ff;
   logic [7:0]  q_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         tf_ff  <= req_tdata[15:0];
         dl_ff  <= req_tdata[39:16];
         df_ff  <= req_tdata[63:40];
         ctf_ff <= req_tdata[95:64];
         q_ff   <= req_tdata[103:96];
      end
   end

   logic [31:0]      ctf_eff;
   logic [DIV_W-1:0] tfok_num;
   logic [DEN_W-1:0] tfok_den;
   logic [40:0]      sdl_in;
   logic [47:0]      tft_in;
   logic [47:0]      dcm_in;

   assign ctf_eff  = (ctf_ff == '0) ? 32'd1 : ctf_ff;
   // saturated tf: 22*tf*2^16 / (12 + 10*tf)
   assign tfok_num = DIV_W'({21'(tf_ff) * 21'd22, 16'b0});
   assign tfok_den = DEN_W'(20'(tf_ff) * 20'd10 + 20'd12);
   assign sdl_in   = 41'(s_eff) * 41'(dl_ff);
   assign tft_in   = 48'(tf_ff) * 48'(tok_eff);
   assign dcm_in   = 48'(mu_eff) * 48'(ctf_eff);

   // ---------------- stage T1 ----------------
   logic [40:0] sdl_ff;
   logic [47:0] tft_ff;
   logic [47:0] dcm_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sdl_ff <= sdl_in;
         tft_ff <= tft_in;
         dcm_ff <= dcm_in;
      end
   end

   // ---------------- arithmetic units ----------------
   logic [DIV_W-1:0] tfok_quo;     // T49
   logic [DIV_W-1:0] piv_quo;      // T50
   log_type          ln_n;         // T22
   log_type          ln_df;        // T22
   log_type          ln_sum;       // T23
   log_type          ln_den;       // T23
   log_type          ln_piv;       // T72
   logic [LOG_W-1:0] piv_sum;
   logic [FRAC_BITS-1:0] exp_frac;
   logic [FRAC_BITS:0]   pm;        // T89

   trs_div u_div_tf (
      .clock (clock),
      .en    (en),
      .num   (tfok_num),
      .den   (tfok_den),
      .quo   (tfok_quo)
   );

   trs_div u_div_piv (
      .clock (clock),
      .en    (en),
      .num   ({sdl_ff, 8'b0}),
      .den   (avg_eff),
      .quo   (piv_quo)
   );

   trs_log u_log_n (
      .clock (clock),
      .en    (en),
      .x     (LOG_W'(25'(docs_ff) + 25'd1)),
      .y     (ln_n)
   );

   trs_log u_log_df (
      .clock (clock),
      .en    (en),
      .x     (LOG_W'(df_ff)),
      .y     (ln_df)
   );

   trs_log u_log_sum (
      .clock (clock),
      .en    (en),
      .x     (LOG_W'(tft_ff) + LOG_W'(dcm_ff)),
      .y     (ln_sum)
   );

   trs_log u_log_den (
      .clock (clock),
      .en    (en),
      .x     (LOG_W'(dcm_ff)),
      .y     (ln_den)
   );

   // pivoted length: (1 - s) + s*dl/avgdl, all in Q.16; zero is taken as one LSB
   assign piv_sum = LOG_W'(ONE_Q16 - s_eff) + piv_quo;

   trs_log u_log_piv (
      .clock (clock),
      .en    (en),
      .x     (piv_sum),
      .y     (ln_piv)
   );

   trs_exp u_exp (
      .clock (clock),
      .en    (en),
      .frac  (exp_frac),
      .mant  (pm)
   );

   // ---------------- idf and Dirichlet terms, T22..T26 ----------------
   logic signed [23:0] idiff_in;
   logic signed [23:0] idiff_ff;     // T23
   logic [23:0]        imag;
   logic [54:0]        iprod_ff;     // T24
   logic               isign_ff;
   logic [21:0]        ddiff_ff;     // T24
   logic signed [23:0] idf_in;
   logic signed [23:0] idf_ff;       // T25
   logic [53:0]        dprod_ff;     // T25
   logic [21:0]        dir_ff;       // T26

   assign idiff_in = $signed({2'b0, ln_n.msb, ln_n.frac}) - $signed({2'b0, ln_df.msb, ln_df.frac});
   assign imag     = idiff_ff[23] ? 24'(-idiff_ff) : idiff_ff;
   // times ln2, truncated toward zero
   assign idf_in   = isign_ff ? -$signed({1'b0, iprod_ff[54:32]})
                              :  $signed({1'b0, iprod_ff[54:32]});

   always_ff @(posedge clock) begin
      if (en) begin
         idiff_ff <= idiff_in;
         iprod_ff <= 55'(imag[22:0]) * 55'(LN2_Q32);
         isign_ff <= idiff_ff[23];
         ddiff_ff <= {ln_sum.msb, ln_sum.frac} - {ln_den.msb, ln_den.frac};
         idf_ff   <= idf_in;
         dprod_ff <= 54'(ddiff_ff) * 54'(LN2_Q32);
         dir_ff   <= dprod_ff[53:32];
      end
   end

   // ---------------- alignment delay lines ----------------
   logic signed [23:0] idf_dly_ff [24];   // [23] at T49
   logic [21:0]        dir_dly_ff [24];   // [23] at T50
   logic [7:0]         q_dly_ff   [52];   // [51] at T52

   always_ff @(posedge clock) begin
      if (en) begin
         idf_dly_ff[0] <= idf_ff;
         dir_dly_ff[0] <= dir_ff;
         q_dly_ff[0]   <= q_ff;
         for (int i = 1; i < 24; i++) begin
            idf_dly_ff[i] <= idf_dly_ff[i-1];
            dir_dly_ff[i] <= dir_dly_ff[i-1];
         end
         for (int i = 1; i < 52; i++) begin
            q_dly_ff[i] <= q_dly_ff[i-1];
         end
      end
   end

   // ---------------- mix, T49..T53 ----------------
   logic signed [42:0] aprod_ff;      // T50
   logic signed [26:0] a_val;
   logic signed [44:0] mprod_a_ff;    // T51
   logic [38:0]        mprod_d_ff;    // T51
   logic signed [45:0] msum;
   logic signed [29:0] mixed_ff;      // T52
   logic [37:0]        qm_in;
   logic [37:0]        qm_ff;         // T53

   assign a_val = aprod_ff[42:16];    // floor of the product over 2^16
   assign msum  = $signed({mprod_a_ff[44], mprod_a_ff}) + $signed({7'b0, mprod_d_ff});
   // a negative or zero mix scores zero
   assign qm_in = (!mixed_ff[29] && (mixed_ff != '0))
                ? 38'(q_dly_ff[51]) * 38'(mixed_ff[28:0]) : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         aprod_ff   <= $signed({1'b0, tfok_quo[17:0]}) * idf_dly_ff[23];
         mprod_a_ff <= $signed({1'b0, alpha_eff}) * a_val;
         mprod_d_ff <= 39'(ONE_Q16 - alpha_eff) * 39'(dir_dly_ff[23]);
         mixed_ff   <= msum[45:16];
         qm_ff      <= qm_in;
      end
   end

   // ---------------- length normalization power, T72..T74 ----------------
   logic [6:0]         msb_m16;
   logic signed [22:0] lg;
   logic signed [40:0] lprod_ff;      // T73
   logic signed [24:0] e_val;
   logic signed [24:0] ne_val;
   logic [8:0]         rs_full;

   assign msb_m16  = 7'(ln_piv.msb) - 7'd16;
   assign lg       = $signed({msb_m16, ln_piv.frac});
   assign e_val    = lprod_ff[40:16];
   assign ne_val   = -e_val;
   assign exp_frac = ne_val[FRAC_BITS-1:0];
   // right shift of the product: 16 minus the integer part of the exponent
   assign rs_full  = 9'd16 - ne_val[24:16];

   always_ff @(posedge clock) begin
      if (en) begin
         lprod_ff <= $signed({1'b0, lambda_eff}) * lg;
      end
   end

   logic [37:0] qm_dly_ff [36];   // [35] at T89
   logic [5:0]  rs_dly_ff [17];   // [16] at T90

   always_ff @(posedge clock) begin
      if (en) begin
         qm_dly_ff[0] <= qm_ff;
         rs_dly_ff[0] <= rs_full[5:0];
         for (int i = 1; i < 36; i++) begin
            qm_dly_ff[i] <= qm_dly_ff[i-1];
         end
         for (int i = 1; i < 17; i++) begin
            rs_dly_ff[i] <= rs_dly_ff[i-1];
         end
      end
   end

   // ---------------- scale and saturate, T89..T91 ----------------
   logic [54:0] val_ff;           // T90
   logic [54:0] shifted;
   logic        clip_in;
   logic [39:0] score_in;
   logic [39:0] score_ff;         // T91
   logic        clip_ff;

   assign shifted  = val_ff >> rs_dly_ff[16];
   assign clip_in  = (shifted > 55'(SCORE_MAX));
   assign score_in = clip_in ? SCORE_MAX : shifted[39:0];

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff   <= 55'(qm_dly_ff[35]) * 55'(pm);
         score_ff <= score_in;
         clip_ff  <= clip_in;
      end
   end

   assign rsp_tdata = score_ff;
   assign rsp_tuser = clip_ff;

   // ---------------- assertions ----------------
   a_clip_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == SCORE_MAX)
      else $error("clipped result is not the saturated score");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(vld_ff))
      else $error("pipeline moved while the output was stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

endmodule

// ----- rtl/core/trs_div.sv -----
// Pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps

module trs_div import trs_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [DIV_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [DIV_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [DIV_W];
   logic [DIV_W-1:0] num_ff [DIV_W];
   logic [DEN_W-1:0] den_ff [DIV_W];
   logic [DIV_W-1:0] quo_ff [DIV_W];

   for (genvar i = 0; i < DIV_W; i++) begin : g_stage
      logic [DEN_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [DIV_W-1:0] num_cur;
      logic [DIV_W-1:0] quo_cur;
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      if (i == 0) begin : g_first
         assign rem_cur = '0;
         assign num_cur = num;
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[i-1];
         assign num_cur = num_ff[i-1];
         assign den_cur = den_ff[i-1];
         assign quo_cur = quo_ff[i-1];
      end

      // shift in the next dividend bit, subtract when it fits
      assign trial  = {rem_cur, num_cur[DIV_W-1]};
      assign ge     = (trial >= {1'b0, den_cur});
      assign rem_in = ge ? DEN_W'(trial - {1'b0, den_cur}) : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            num_ff[i] <= num_cur << 1;
            den_ff[i] <= den_cur;
            quo_ff[i] <= {quo_cur[DIV_W-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[DIV_W-1];

endmodule

// ----- rtl/core/trs_log.sv -----
// Pipelined log2: leading-zero normalize, then one squaring per fraction bit.
`timescale 1ns / 1ps

module trs_log import trs_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [LOG_W-1:0] x,
   output log_type          y
);

   localparam int NORM_STEPS = 6;

   logic [63:0]          norm_ff [NORM_STEPS];
   logic [MSB_W-1:0]     lz_ff   [NORM_STEPS];
   logic [31:0]          m_ff    [FRAC_BITS];
   logic [MSB_W-1:0]     msb_ff  [FRAC_BITS];
   logic [FRAC_BITS-1:0] frac_ff [FRAC_BITS];
   logic [63:0]          x_ext;

   // zero counts as one
   assign x_ext = (x == '0) ? 64'd1 : {{(64-LOG_W){1'b0}}, x};

   for (genvar i = 0; i < NORM_STEPS; i++) begin : g_norm
      localparam int STEP = 32 >> i;
      logic [63:0]      v_cur;
      logic [MSB_W-1:0] z_cur;
      logic [63:0]      norm_in;
      logic [MSB_W-1:0] lz_in;

      if (i == 0) begin : g_first
         assign v_cur = x_ext;
         assign z_cur = '0;
      end else begin : g_next
         assign v_cur = norm_ff[i-1];
         assign z_cur = lz_ff[i-1];
      end

      always_comb begin
         if (v_cur[63 -: STEP] == '0) begin
            norm_in = v_cur << STEP;
            lz_in   = z_cur + MSB_W'(STEP);
         end else begin
            norm_in = v_cur;
            lz_in   = z_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            norm_ff[i] <= norm_in;
            lz_ff[i]   <= lz_in;
         end
      end
   end

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
      logic [31:0]          m_cur;
      logic [MSB_W-1:0]     msb_cur;
      logic [FRAC_BITS-1:0] f_cur;
      logic [63:0]          sq;
      logic [32:0]          t;
      logic [31:0]          m_in;
      logic [FRAC_BITS-1:0] frac_in;

      if (k == 0) begin : g_first
         assign m_cur   = norm_ff[NORM_STEPS-1][63:32];
         assign msb_cur = MSB_W'(63) - lz_ff[NORM_STEPS-1];
         assign f_cur   = '0;
      end else begin : g_next
         assign m_cur   = m_ff[k-1];
         assign msb_cur = msb_ff[k-1];
         assign f_cur   = frac_ff[k-1];
      end

      // square the mantissa; a carry past two gives a one bit and halves it
      assign sq      = 64'(m_cur) * 64'(m_cur);
      assign t       = sq[63:31];
      assign m_in    = t[32] ? t[32:1] : t[31:0];
      assign frac_in = {f_cur[FRAC_BITS-2:0], t[32]};

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[k]    <= m_in;
            msb_ff[k]  <= msb_cur;
            frac_ff[k] <= frac_in;
         end
      end
   end

   assign y.msb  = msb_ff[FRAC_BITS-1];
   assign y.frac = frac_ff[FRAC_BITS-1];

endmodule

// ----- rtl/core/trs_exp.sv -----
// Pipelined exp2 mantissa: one multiply by a root of two per fraction bit.
`timescale 1ns / 1ps

module trs_exp import trs_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS-1:0] frac,
   output logic [FRAC_BITS:0]   mant
);

   logic [30:0]          r_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] f_ff [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
      localparam logic [30:0] ROOT = exp2_root(k + 1);
      logic [30:0]          r_cur;
      logic [FRAC_BITS-1:0] f_cur;
      logic [61:0]          prod;
      logic [30:0]          r_in;

      if (k == 0) begin : g_first
         assign r_cur = 31'h4000_0000;
         assign f_cur = frac;
      end else begin : g_next
         assign r_cur = r_ff[k-1];
         assign f_cur = f_ff[k-1];
      end

      assign prod = 62'(r_cur) * 62'(ROOT);
      assign r_in = f_cur[FRAC_BITS-1-k] ? prod[60:30] : r_cur;

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k] <= r_in;
            f_ff[k] <= f_cur;
         end
      end
   end

   assign mant = r_ff[FRAC_BITS-1][30 -: (FRAC_BITS+1)];

endmodule

// ----- tb/sv/term_relevance_scorer_tb.sv -----
// Self-checking testbench of the term relevance scorer: directed, register and random tests.
`timescale 1ns / 1ps

module term_relevance_scorer_tb;
   import trs_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // term_in_doc[15:0], doc_length[39:16], docs_with_term[63:40],
   // term_in_corpus[95:64], term_in_query[103:96]
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // score[39:0]
   logic [39:0]  rsp_tdata;
   // clipped[0]
   logic         rsp_tuser;
   logic         csr_wen;
   logic [2:0]   csr_addr;
   logic [31:0]  csr_wdata;

   typedef struct {
      bit [39:0] score;
      bit        clipped;
   } score_type;

   // Expected scores, oldest first.
   score_type score_queue[$];
   int        mismatch_count = 0;
   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;

   // Local copy of the register file.
   bit [63:0] slope_q, mu_q, alpha_q, lambda_q, avg_q, docs_q, tokens_q;

   term_relevance_scorer i_dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint log2_q(input bit [63:0] x, input int fb);
      int        msb;
      bit [63:0] m;
      longint    frac;
      if (x == 0) begin
         x = 1;
      end
      msb = 63;
      while (x[msb] == 1'b0) begin
         msb--;
      end
      m = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
      frac = 0;
      for (int k = 0; k < FRAC_BITS; k++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return longint'(msb - fb) * (64'sd1 << FRAC_BITS) + frac;
   endfunction

   function automatic bit [63:0] root_of(input bit [63:0] v_in);
      bit [63:0] v, r, b;
      v = v_in;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) begin
         b = b >> 2;
      end
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(frac / 2^F) in Q.30
   function automatic bit [63:0] pow2_mant(input bit [63:0] frac);
      bit [63:0] r, c;
      r = 64'd1 << 30;
      c = 64'd2 << 30;
      for (int k = 1; k <= FRAC_BITS; k++) begin
         c = root_of(c << 30);
         if (frac[FRAC_BITS - k]) begin
            r = (r * c) >> 30;
         end
      end
      return r;
   endfunction

   // Multiply by ln2 and truncate toward zero.
   function automatic longint mul_ln2(input longint v);
      bit [63:0] mag;
      if (v >= 0) begin
         return longint'((64'(v) * 64'(LN2_Q32)) >> 32);
      end
      mag = 64'(-v);
      return -longint'((mag * 64'(LN2_Q32)) >> 32);
   endfunction

   function automatic score_type predict_score(input bit [103:0] d);
      bit [63:0] tf, dl, df, ctf, q, s, alpha, lambda, mu, avg, tot;
      bit [63:0] tfok, den, piv, frac, pm, val, lim;
      longint    idf, dir, a, mixed, lg, ne, ip, sh;
      score_type res;
      tf  = 64'(d[15:0]);
      dl  = 64'(d[39:16]);
      df  = 64'(d[63:40]);
      ctf = 64'(d[95:64]);
      q   = 64'(d[103:96]);
      s      = (slope_q  > 65536) ? 65536 : slope_q;
      alpha  = (alpha_q  > 65536) ? 65536 : alpha_q;
      lambda = (lambda_q > 65536) ? 65536 : lambda_q;
      mu  = (mu_q == 0) ? 1 : mu_q;
      avg = (avg_q == 0) ? 1 : avg_q;
      tot = (tokens_q == 0) ? 1 : tokens_q;
      if (df == 0) df = 1;
      if (ctf == 0) ctf = 1;
      res.score   = '0;
      res.clipped = 1'b0;

      tfok  = (22 * tf * (64'd1 << FRAC_BITS)) / (12 + 10 * tf);
      idf   = mul_ln2(log2_q(docs_q + 1, 0) - log2_q(df, 0));
      den   = mu * ctf;
      dir   = mul_ln2(log2_q(tf * tot + den, 0) - log2_q(den, 0));
      a     = (longint'(tfok) * idf) >>> FRAC_BITS;
      mixed = (longint'(alpha) * a + longint'(65536 - alpha) * dir) >>> 16;

      piv = (((65536 - s) << FRAC_BITS) >> 16)
          + (s * dl * (64'd1 << (FRAC_BITS - 8))) / avg;
      if (piv == 0) piv = 1;
      lg   = log2_q(piv, FRAC_BITS);
      ne   = -((longint'(lambda) * lg) >>> 16);
      frac = 64'(ne) & ((64'd1 << FRAC_BITS) - 1);
      ip   = (ne - longint'(frac)) >>> FRAC_BITS;
      pm   = pow2_mant(frac) >> (30 - FRAC_BITS);

      if (mixed > 0 && q != 0) begin
         val = q * 64'(mixed) * pm;
         sh  = ip - FRAC_BITS;
         if (sh >= 0) begin
            lim = (sh >= 40) ? 0 : (64'(SCORE_MAX) >> sh);
            if (sh >= 40 || val > lim) begin
               res.score   = SCORE_MAX;
               res.clipped = 1'b1;
            end else begin
               res.score = 40'(val << sh);
            end
         end else if (-sh < 64) begin
            val = val >> (-sh);
            if (val > 64'(SCORE_MAX)) begin
               res.score   = SCORE_MAX;
               res.clipped = 1'b1;
            end else begin
               res.score = 40'(val);
            end
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Write one register at the next edge and mirror it locally; the caller drops the enable.
   task automatic write_reg(input csr_idx_type idx, input bit [31:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SLOPE:  slope_q  = 64'(value & 32'h1_FFFF);
         CSR_MU:     mu_q     = 64'(value & 32'hFFFF);
         CSR_ALPHA:  alpha_q  = 64'(value & 32'h1_FFFF);
         CSR_LAMBDA: lambda_q = 64'(value & 32'h1_FFFF);
         CSR_AVG:    avg_q    = 64'(value);
         CSR_DOCS:   docs_q   = 64'(value & 32'hFF_FFFF);
         CSR_TOKENS: tokens_q = 64'(value);
         default: ;
      endcase
   endtask

   task automatic write_all(input bit [31:0] s, input bit [31:0] mu, input bit [31:0] alpha,
                            input bit [31:0] lambda, input bit [31:0] avg,
                            input bit [31:0] docs, input bit [31:0] tokens);
      write_reg(CSR_SLOPE, s);
      write_reg(CSR_MU, mu);
      write_reg(CSR_ALPHA, alpha);
      write_reg(CSR_LAMBDA, lambda);
      write_reg(CSR_AVG, avg);
      write_reg(CSR_DOCS, docs);
      write_reg(CSR_TOKENS, tokens);
      csr_wen <= 1'b0;
   endtask

   // Send one posting; the expected score is queued at the transfer edge.
   task automatic send_posting(input bit [15:0] tf, input bit [23:0] dl, input bit [23:0] df,
                               input bit [31:0] ctf, input bit [7:0] q);
      logic accepted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {q, ctf, df, dl, tf};
      // Sample the ready between edges: it only moves on the rising edge.
      do begin
         @(negedge clock);
         accepted = req_tready;
         @(posedge clock);
      end while (!accepted);
      score_queue.insert(score_queue.size(), predict_score({q, ctf, df, dl, tf}));
   endtask

   // Drop valid and hold until every score has come back, then let the pipe settle.
   task automatic drain_scores();
      req_tvalid <= 1'b0;
      while (score_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);
   endtask

   // Mostly plausible postings, the rest over the full width of each field.
   task automatic send_random_posting();
      bit [15:0] tf;
      bit [23:0] dl, df;
      bit [31:0] ctf;
      bit [7:0]  q;
      if ($urandom_range(99) < 70) begin
         tf  = 16'($urandom_range(1, 40));
         dl  = 24'($urandom_range(1, 4000));
         df  = 24'($urandom_range(1, 32'((docs_q > 1000) ? 1000 : docs_q + 1)));
         ctf = $urandom_range(32'(tf), 32'(tf) + 100000);
         q   = 8'($urandom_range(1, 4));
      end else begin
         tf  = 16'($urandom);
         dl  = 24'($urandom);
         df  = 24'($urandom);
         ctf = $urandom;
         q   = 8'($urandom);
      end
      send_posting(tf, dl, df, ctf, q);
   endtask

   // Check each score transfer against the oldest expectation.
   always @(negedge clock) begin
      score_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (score_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected score %h", rsp_tdata));
         end else begin
            want = score_queue.pop_front();
            if (rsp_tdata !== want.score) begin
               report_mismatch($sformatf("score %h, want %h", rsp_tdata, want.score));
            end
            if (rsp_tuser !== want.clipped) begin
               report_mismatch($sformatf("clipped %b, want %b", rsp_tuser, want.clipped));
            end
         end
      end
   end

   // Stall the score channel at the current rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------- tests

   // Register defaults after reset, field extremes and the special cases.
   task automatic test_directed();
      send_posting(1, 1, 1, 1, 1);
      send_posting(16'hFFFF, 24'hFF_FFFF, 1, 32'hFFFF_FFFF, 8'hFF);
      send_posting(0, 0, 0, 0, 1);          // zero df and ctf taken as one
      send_posting(5, 100, 1, 50, 0);       // query count zero gives zero
      send_posting(5, 100, 24'hFF_FFFF, 50, 3); // df above N+1: negative mix
      drain_scores();
      write_all(13107, 2000, 19661, 45875, 1000 << 8, 1000000, 32'd500000000);
      send_posting(3, 800, 20, 3000, 2);
      send_posting(3, 1, 1, 1, 8'hFF);
      send_posting(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      send_posting(1, 24'hFF_FFFF, 999, 1, 1);
      drain_scores();
      // Vanishing pivot with full exponent: drives the score into saturation.
      write_all(65536, 1, 65536, 65536, 32'hFFFF_FFFF, 32'hFF_FFFF, 32'hFFFF_FFFF);
      send_posting(16'hFFFF, 1, 1, 1, 8'hFF);
      send_posting(1, 0, 1, 1, 8'hFF);
      send_posting(200, 5, 2, 7, 9);
      drain_scores();
   endtask

   // Zero and out-of-range register values, then the plain extremes.
   task automatic test_register_extremes();
      write_all(0, 0, 0, 0, 0, 0, 0);
      send_posting(7, 300, 1, 40, 2);
      send_posting(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      drain_scores();
      write_all(32'h1_FFFF, 65535, 32'h1_FFFF, 32'h1_FFFF, 256, 32'hFF_FFFF, 1);
      send_posting(7, 300, 1, 40, 2);
      send_posting(1, 24'hFF_FFFF, 5, 1, 8'hFF);
      drain_scores();
      write_all(0, 1, 65536, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
      send_posting(7, 300, 1, 40, 2);
      send_posting(16'hFFFF, 1, 2, 1, 8'hFF);
      drain_scores();
   endtask

   // Random postings under one register setting and one idling pattern.
   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      write_all($urandom_range(0, 65536), $urandom_range(1, 65535), $urandom_range(0, 65536),
                $urandom_range(0, 65536), $urandom_range(256, 4000 << 8),
                $urandom_range(1, 2000000), $urandom);
      repeat (count) send_random_posting();
      drain_scores();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_addr   = CSR_SLOPE;
      csr_wdata  = '0;
      slope_q  = 13107;
      mu_q     = 2000;
      alpha_q  = 19661;
      lambda_q = 45875;
      avg_q    = 256;
      docs_q   = 1;
      tokens_q = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_random_phase(0, 0, 250);
      test_random_phase(77, 0, 250);
      test_random_phase(0, 77, 250);
      test_random_phase(22, 22, 250);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Hard stop if the block hangs.
   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
